/* rtl/qfe_pkg.sv */
// Shared constants and types of the quadrupole field evaluator.
`timescale 1ns / 1ps
package qfe_pkg;

    // Trig words: signed Q2.30 halves of a packed 64-bit register.
    localparam int TRIG_W     = 32;
    localparam int TRIG_FRAC  = 30;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;

    // Datapath words are held in 64-bit two's complement at most.
    localparam int MAX_W      = 64;

    // Wide operands are split into chunks of this many bits per multiplier.
    localparam int MUL_CHUNK  = 31;

    localparam logic [CFG_DATA_W-1:0] TRIG_RESET = CFG_DATA_W'(1) << TRIG_FRAC;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_TRIG     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_TRIG      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_TRIG     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNET_LENGTH = 4'd7;

    // Pipeline stage map. A multiply occupies its stage and the next one.
    localparam int ST_DIFF  = 0;
    localparam int ST_L1    = 1;
    localparam int ST_L2    = 3;
    localparam int ST_POS   = 5;
    localparam int ST_L3    = 6;
    localparam int ST_ROT   = 8;
    localparam int ST_L4    = 9;
    localparam int ST_NEG   = 11;
    localparam int ST_L5    = 12;
    localparam int ST_BACK  = 14;
    localparam int ST_L6    = 15;
    localparam int ST_L7    = 17;
    localparam int ST_OUT   = 19;
    localparam int STAGES   = 20;

    typedef struct packed {
        logic ld_part;
        logic ld_sum;
    } t_mul_en;

endpackage

/* rtl/qfe_pos_if.sv */
// Input channel: one query position per word.
`timescale 1ns / 1ps
interface qfe_pos_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

/* rtl/qfe_field_if.sv */
// Output channel: one lab-frame field vector and window flag per word.
`timescale 1ns / 1ps
interface qfe_field_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] field_x;
    logic signed [COORD_WIDTH-1:0] field_y;
    logic signed [COORD_WIDTH-1:0] field_z;
    logic                          inside_res;

    modport source (output valid, output field_x, output field_y, output field_z,
                    output inside_res, input ready);
    modport sink   (input valid, input field_x, input field_y, input field_z,
                    input inside_res, output ready);
endinterface

/* rtl/qfe_mul.sv */
// Two-stage chunked signed multiplier with floor shift and truncation.
`timescale 1ns / 1ps
module qfe_mul import qfe_pkg::*; #(
    parameter int A_W   = 33,
    parameter int B_W   = 32,
    parameter int SHIFT = 30,
    parameter int O_W   = 35
) (
    input  logic                  i_clk,
    input  t_mul_en               i_en,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    output logic signed [O_W-1:0] o_p
);

    localparam int NC     = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int EXT_W  = NC * MUL_CHUNK;
    localparam int PP_W   = MUL_CHUNK + 1 + B_W;
    localparam int FULL_W = A_W + B_W;

    logic signed [EXT_W-1:0]     a_ext;
    logic signed [MUL_CHUNK:0]   op [NC];
    logic signed [PP_W-1:0]      r_pp [NC];
    logic signed [FULL_W-1:0]    n_full;
    logic signed [FULL_W-1:0]    n_shift;
    logic signed [O_W-1:0]       r_p;

    assign a_ext = EXT_W'(i_a);

    // Low chunks are unsigned, the top chunk carries the sign.
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            op[i] = {(i == NC - 1) ? a_ext[i*MUL_CHUNK + MUL_CHUNK - 1] : 1'b0,
                     a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_part) begin
            for (int i = 0; i < NC; i++) begin
                r_pp[i] <= op[i] * i_b;
            end
        end
    end

    // Recombine partials; arithmetic shift gives the floor.
    always_comb begin
        n_full = '0;
        for (int i = 0; i < NC; i++) begin
            n_full = n_full + (FULL_W'(r_pp[i]) <<< (i * MUL_CHUNK));
        end
        n_shift = n_full >>> SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_sum) begin
            r_p <= n_shift[O_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/qfe_cfg.sv */
// Configuration register file of the quadrupole field evaluator.
`timescale 1ns / 1ps
module qfe_cfg import qfe_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic signed [COORD_WIDTH-1:0] o_center_x,
    output logic signed [COORD_WIDTH-1:0] o_center_y,
    output logic signed [COORD_WIDTH-1:0] o_center_z,
    output logic signed [TRIG_W-1:0]      o_tilt_sin,
    output logic signed [TRIG_W-1:0]      o_tilt_cos,
    output logic signed [TRIG_W-1:0]      o_yaw_sin,
    output logic signed [TRIG_W-1:0]      o_yaw_cos,
    output logic signed [TRIG_W-1:0]      o_roll_sin,
    output logic signed [TRIG_W-1:0]      o_roll_cos,
    output logic signed [COORD_WIDTH-1:0] o_gradient,
    output logic [COORD_WIDTH-2:0]        o_magnet_length
);

    logic signed [COORD_WIDTH-1:0] r_center_x;
    logic signed [COORD_WIDTH-1:0] r_center_y;
    logic signed [COORD_WIDTH-1:0] r_center_z;
    logic [CFG_DATA_W-1:0]         r_tilt;
    logic [CFG_DATA_W-1:0]         r_yaw;
    logic [CFG_DATA_W-1:0]         r_roll;
    logic signed [COORD_WIDTH-1:0] r_gradient;
    logic [COORD_WIDTH-2:0]        r_magnet_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x      <= '0;
            r_center_y      <= '0;
            r_center_z      <= '0;
            r_tilt          <= TRIG_RESET;
            r_yaw           <= TRIG_RESET;
            r_roll          <= TRIG_RESET;
            r_gradient      <= '0;
            r_magnet_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X:      r_center_x      <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_CENTER_Y:      r_center_y      <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_CENTER_Z:      r_center_z      <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_TILT_TRIG:     r_tilt          <= i_cfg_data;
                CFG_YAW_TRIG:      r_yaw           <= i_cfg_data;
                CFG_ROLL_TRIG:     r_roll          <= i_cfg_data;
                CFG_GRADIENT:      r_gradient      <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_MAGNET_LENGTH: r_magnet_length <= i_cfg_data[COORD_WIDTH-2:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_center_x      = r_center_x;
    assign o_center_y      = r_center_y;
    assign o_center_z      = r_center_z;
    assign o_tilt_sin      = r_tilt[CFG_DATA_W-1:TRIG_W];
    assign o_tilt_cos      = r_tilt[TRIG_W-1:0];
    assign o_yaw_sin       = r_yaw[CFG_DATA_W-1:TRIG_W];
    assign o_yaw_cos       = r_yaw[TRIG_W-1:0];
    assign o_roll_sin      = r_roll[CFG_DATA_W-1:TRIG_W];
    assign o_roll_cos      = r_roll[TRIG_W-1:0];
    assign o_gradient      = r_gradient;
    assign o_magnet_length = r_magnet_length;

endmodule

/* rtl/qfe_pipe_ctl.sv */
// Valid bits and per-stage load enables of the evaluator pipeline.
`timescale 1ns / 1ps
module qfe_pipe_ctl import qfe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic [STAGES-1:0] o_en
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES:0]   w_en;

    // A stage loads when it is empty or its word moves on; bubbles collapse.
    always_comb begin
        w_en[STAGES] = i_out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = (w_en[STAGES-1:0] & {r_vld[STAGES-2:0], i_in_valid})
              | (~w_en[STAGES-1:0] & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[STAGES-1];
    assign o_en        = w_en[STAGES-1:0];

endmodule

/* rtl/quadrupole_field_eval_core.sv */
// Top level of the hard-edge quadrupole field evaluator.
`timescale 1ns / 1ps
// Evaluates the field of a hard-edge quadrupole at one query position per
// clock while the output is not stalled. A position is offset by the magnet
// center, rotated into the magnet frame by yaw/tilt and roll, tested against
// the length window, multiplied by the gradient and rotated back to the lab
// frame. Throughput is one word per cycle while the output is not stalled,
// set by the 20-stage register pipeline in which every multiply takes two
// stages (31-bit operand chunks multiplied, then summed and shifted). Empty
// stages fill while the output is stalled, so input words are taken until all
// 20 stages hold a word. The user must see that configuration is written
// only while no word is in flight; the block itself does not enforce this.
// Writes to indexes past the magnet length are dropped.
module quadrupole_field_eval_core import qfe_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    qfe_pos_if.sink               i_pos,
    qfe_field_if.source           o_field
);

    function automatic int cap_w(input int w);
        return (w > MAX_W) ? MAX_W : w;
    endfunction

    localparam int CW   = COORD_WIDTH;
    localparam int TG   = TRIG_W - TRIG_FRAC;
    localparam int WD   = CW + 1;
    localparam int W1   = cap_w(WD + TG);
    localparam int W2   = cap_w(W1 + TG);
    localparam int WXP  = cap_w(W1 + 1);
    localparam int WYP  = cap_w(W2 + 2);
    localparam int WXPC = cap_w(WXP + TG);
    localparam int WYPC = cap_w(WYP + TG);
    localparam int WR   = cap_w(WYPC + 1);
    localparam int WG   = cap_w(WR + CW - FRAC_BITS);
    localparam int WBN  = cap_w(WG + 1);
    localparam int W5   = cap_w(WBN + TG);
    localparam int WXB  = cap_w(W5 + 1);
    localparam int W6   = cap_w(WXB + TG);
    localparam int W7   = cap_w(W6 + TG);

    // Configuration
    logic signed [CW-1:0]     center_x, center_y, center_z, gradient;
    logic signed [TRIG_W-1:0] sa, ca, sb, cb, sr, cr;
    logic [CW-2:0]            magnet_length;

    qfe_cfg #(.COORD_WIDTH(CW)) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_center_x      (center_x),
        .o_center_y      (center_y),
        .o_center_z      (center_z),
        .o_tilt_sin      (sa),
        .o_tilt_cos      (ca),
        .o_yaw_sin       (sb),
        .o_yaw_cos       (cb),
        .o_roll_sin      (sr),
        .o_roll_cos      (cr),
        .o_gradient      (gradient),
        .o_magnet_length (magnet_length)
    );

    // Pipeline control
    logic [STAGES-1:0] en;

    qfe_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pos.valid),
        .i_out_ready (o_field.ready),
        .o_in_ready  (i_pos.ready),
        .o_out_valid (o_field.valid),
        .o_en        (en)
    );

    t_mul_en en_l1, en_l2, en_l3, en_l4, en_l5, en_l6, en_l7;

    assign en_l1 = '{ld_part: en[ST_L1], ld_sum: en[ST_L1+1]};
    assign en_l2 = '{ld_part: en[ST_L2], ld_sum: en[ST_L2+1]};
    assign en_l3 = '{ld_part: en[ST_L3], ld_sum: en[ST_L3+1]};
    assign en_l4 = '{ld_part: en[ST_L4], ld_sum: en[ST_L4+1]};
    assign en_l5 = '{ld_part: en[ST_L5], ld_sum: en[ST_L5+1]};
    assign en_l6 = '{ld_part: en[ST_L6], ld_sum: en[ST_L6+1]};
    assign en_l7 = '{ld_part: en[ST_L7], ld_sum: en[ST_L7+1]};

    // Offset from the magnet center
    logic signed [WD-1:0] r_dx, r_dy, r_dz;

    always_ff @(posedge i_clk) begin
        if (en[ST_DIFF]) begin
            r_dx <= WD'(i_pos.pos_x) - WD'(center_x);
            r_dy <= WD'(i_pos.pos_y) - WD'(center_y);
            r_dz <= WD'(i_pos.pos_z) - WD'(center_z);
        end
    end

    // First trig products
    logic signed [W1-1:0] m_dx_cb, m_dz_sb, m_dx_sa, m_dy_ca;
    logic signed [W1-1:0] m_dz_sa, m_dx_ca, m_dy_sa, m_dz_ca;

    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dx_cb (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dx), .i_b(cb), .o_p(m_dx_cb));
    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dz_sb (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dz), .i_b(sb), .o_p(m_dz_sb));
    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dx_sa (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dx), .i_b(sa), .o_p(m_dx_sa));
    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dy_ca (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dy), .i_b(ca), .o_p(m_dy_ca));
    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dz_sa (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dz), .i_b(sa), .o_p(m_dz_sa));
    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dx_ca (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dx), .i_b(ca), .o_p(m_dx_ca));
    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dy_sa (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dy), .i_b(sa), .o_p(m_dy_sa));
    qfe_mul #(.A_W(WD), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W1)) u_dz_ca (
        .i_clk(i_clk), .i_en(en_l1), .i_a(r_dz), .i_b(ca), .o_p(m_dz_ca));

    // Second trig products; hold the single products alongside
    logic signed [W2-1:0]  m_dxs_sb, m_dzs_cb, m_dxc_sb, m_dzc_cb;
    logic signed [WXP-1:0] r3_xp, r4_xp;
    logic signed [W1-1:0]  r3_dy_ca, r3_dy_sa, r4_dy_ca, r4_dy_sa;

    qfe_mul #(.A_W(W1), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W2)) u_dxs_sb (
        .i_clk(i_clk), .i_en(en_l2), .i_a(m_dx_sa), .i_b(sb), .o_p(m_dxs_sb));
    qfe_mul #(.A_W(W1), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W2)) u_dzs_cb (
        .i_clk(i_clk), .i_en(en_l2), .i_a(m_dz_sa), .i_b(cb), .o_p(m_dzs_cb));
    qfe_mul #(.A_W(W1), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W2)) u_dxc_sb (
        .i_clk(i_clk), .i_en(en_l2), .i_a(m_dx_ca), .i_b(sb), .o_p(m_dxc_sb));
    qfe_mul #(.A_W(W1), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W2)) u_dzc_cb (
        .i_clk(i_clk), .i_en(en_l2), .i_a(m_dz_ca), .i_b(cb), .o_p(m_dzc_cb));

    always_ff @(posedge i_clk) begin
        if (en[ST_L2]) begin
            r3_xp    <= WXP'(m_dx_cb) + WXP'(m_dz_sb);
            r3_dy_ca <= m_dy_ca;
            r3_dy_sa <= m_dy_sa;
        end
        if (en[ST_L2+1]) begin
            r4_xp    <= r3_xp;
            r4_dy_ca <= r3_dy_ca;
            r4_dy_sa <= r3_dy_sa;
        end
    end

    // Magnet-frame position after yaw and tilt
    logic signed [WXP-1:0] r_xp;
    logic signed [WYP-1:0] r_yp, r_zp, n_yp, n_zp;

    always_comb begin
        n_yp = -WYP'(m_dxs_sb) + WYP'(r4_dy_ca) + WYP'(m_dzs_cb);
        n_zp = -WYP'(m_dxc_sb) - WYP'(r4_dy_sa) + WYP'(m_dzc_cb);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_POS]) begin
            r_xp <= r4_xp;
            r_yp <= n_yp;
            r_zp <= n_zp;
        end
    end

    // Roll products and the window test
    logic signed [WXPC-1:0] m_xp_cr, m_xp_sr;
    logic signed [WYPC-1:0] m_yp_sr, m_yp_cr;
    logic                   n_inside;
    logic [ST_OUT-1:ST_L3]  r_inside;

    qfe_mul #(.A_W(WXP), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(WXPC)) u_xp_cr (
        .i_clk(i_clk), .i_en(en_l3), .i_a(r_xp), .i_b(cr), .o_p(m_xp_cr));
    qfe_mul #(.A_W(WXP), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(WXPC)) u_xp_sr (
        .i_clk(i_clk), .i_en(en_l3), .i_a(r_xp), .i_b(sr), .o_p(m_xp_sr));
    qfe_mul #(.A_W(WYP), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(WYPC)) u_yp_sr (
        .i_clk(i_clk), .i_en(en_l3), .i_a(r_yp), .i_b(sr), .o_p(m_yp_sr));
    qfe_mul #(.A_W(WYP), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(WYPC)) u_yp_cr (
        .i_clk(i_clk), .i_en(en_l3), .i_a(r_yp), .i_b(cr), .o_p(m_yp_cr));

    // Both window edges count as inside.
    assign n_inside = !r_zp[WYP-1] && ($unsigned(r_zp) <= WYP'(magnet_length));

    always_ff @(posedge i_clk) begin
        if (en[ST_L3]) begin
            r_inside[ST_L3] <= n_inside;
        end
        for (int k = ST_L3 + 1; k < ST_OUT; k++) begin
            if (en[k]) begin
                r_inside[k] <= r_inside[k-1];
            end
        end
    end

    // Rolled transverse position
    logic signed [WR-1:0] r_xr, r_yr, n_xr, n_yr;

    always_comb begin
        n_xr = WR'(m_xp_cr) + WR'(m_yp_sr);
        n_yr = -WR'(m_xp_sr) + WR'(m_yp_cr);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_ROT]) begin
            r_xr <= n_xr;
            r_yr <= n_yr;
        end
    end

    // Gradient products and sign flip
    logic signed [WG-1:0]  m_g_yr, m_g_xr;
    logic signed [WBN-1:0] r_bx, r_by;

    qfe_mul #(.A_W(WR), .B_W(CW), .SHIFT(FRAC_BITS), .O_W(WG)) u_g_yr (
        .i_clk(i_clk), .i_en(en_l4), .i_a(r_yr), .i_b(gradient), .o_p(m_g_yr));
    qfe_mul #(.A_W(WR), .B_W(CW), .SHIFT(FRAC_BITS), .O_W(WG)) u_g_xr (
        .i_clk(i_clk), .i_en(en_l4), .i_a(r_xr), .i_b(gradient), .o_p(m_g_xr));

    always_ff @(posedge i_clk) begin
        if (en[ST_NEG]) begin
            r_bx <= -WBN'(m_g_yr);
            r_by <= -WBN'(m_g_xr);
        end
    end

    // Inverse roll
    logic signed [W5-1:0]  m_bx_cr, m_by_sr, m_bx_sr, m_by_cr;
    logic signed [WXB-1:0] r_xb, r_yb, n_xb, n_yb;

    qfe_mul #(.A_W(WBN), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W5)) u_bx_cr (
        .i_clk(i_clk), .i_en(en_l5), .i_a(r_bx), .i_b(cr), .o_p(m_bx_cr));
    qfe_mul #(.A_W(WBN), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W5)) u_by_sr (
        .i_clk(i_clk), .i_en(en_l5), .i_a(r_by), .i_b(sr), .o_p(m_by_sr));
    qfe_mul #(.A_W(WBN), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W5)) u_bx_sr (
        .i_clk(i_clk), .i_en(en_l5), .i_a(r_bx), .i_b(sr), .o_p(m_bx_sr));
    qfe_mul #(.A_W(WBN), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W5)) u_by_cr (
        .i_clk(i_clk), .i_en(en_l5), .i_a(r_by), .i_b(cr), .o_p(m_by_cr));

    always_comb begin
        n_xb = WXB'(m_bx_cr) - WXB'(m_by_sr);
        n_yb = WXB'(m_bx_sr) + WXB'(m_by_cr);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_BACK]) begin
            r_xb <= n_xb;
            r_yb <= n_yb;
        end
    end

    // Inverse tilt and yaw
    logic signed [W6-1:0] m_ysa, m_xb_cb, m_xb_sb, m_yb_ca;
    logic signed [W7-1:0] m_ysa_sb, m_ysa_cb;
    logic signed [CW-1:0] r17_xb_cb, r17_xb_sb, r17_yb_ca;
    logic signed [CW-1:0] r18_xb_cb, r18_xb_sb, r18_yb_ca;

    qfe_mul #(.A_W(WXB), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W6)) u_yb_sa (
        .i_clk(i_clk), .i_en(en_l6), .i_a(r_yb), .i_b(sa), .o_p(m_ysa));
    qfe_mul #(.A_W(WXB), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W6)) u_xb_cb (
        .i_clk(i_clk), .i_en(en_l6), .i_a(r_xb), .i_b(cb), .o_p(m_xb_cb));
    qfe_mul #(.A_W(WXB), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W6)) u_xb_sb (
        .i_clk(i_clk), .i_en(en_l6), .i_a(r_xb), .i_b(sb), .o_p(m_xb_sb));
    qfe_mul #(.A_W(WXB), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W6)) u_yb_ca (
        .i_clk(i_clk), .i_en(en_l6), .i_a(r_yb), .i_b(ca), .o_p(m_yb_ca));

    qfe_mul #(.A_W(W6), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W7)) u_ysa_sb (
        .i_clk(i_clk), .i_en(en_l7), .i_a(m_ysa), .i_b(sb), .o_p(m_ysa_sb));
    qfe_mul #(.A_W(W6), .B_W(TRIG_W), .SHIFT(TRIG_FRAC), .O_W(W7)) u_ysa_cb (
        .i_clk(i_clk), .i_en(en_l7), .i_a(m_ysa), .i_b(cb), .o_p(m_ysa_cb));

    // Only the low word of these survives into the result.
    always_ff @(posedge i_clk) begin
        if (en[ST_L7]) begin
            r17_xb_cb <= CW'(m_xb_cb);
            r17_xb_sb <= CW'(m_xb_sb);
            r17_yb_ca <= CW'(m_yb_ca);
        end
        if (en[ST_L7+1]) begin
            r18_xb_cb <= r17_xb_cb;
            r18_xb_sb <= r17_xb_sb;
            r18_yb_ca <= r17_yb_ca;
        end
    end

    // Output register; zero the field outside the window
    logic signed [CW-1:0] r_fx, r_fy, r_fz, n_fx, n_fy, n_fz;
    logic                 r_in_o;

    always_comb begin
        if (r_inside[ST_OUT-1]) begin
            n_fx = r18_xb_cb - CW'(m_ysa_sb);
            n_fy = r18_yb_ca;
            n_fz = r18_xb_sb + CW'(m_ysa_cb);
        end else begin
            n_fx = '0;
            n_fy = '0;
            n_fz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_fx   <= n_fx;
            r_fy   <= n_fy;
            r_fz   <= n_fz;
            r_in_o <= r_inside[ST_OUT-1];
        end
    end

    assign o_field.field_x    = r_fx;
    assign o_field.field_y    = r_fy;
    assign o_field.field_z    = r_fz;
    assign o_field.inside_res = r_in_o;

endmodule
